@@ rtl/vhi_pkg.sv @@
// Package for the voicing Hermite interpolator: mode codes, status codes,
// state encoding and default sizes. No dependencies.
`default_nettype none
package vhi_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int RATIO_EXTRA     = 10;
    localparam int TIME_W          = 32;
    localparam int VAL_W           = 19;
    localparam int OUT_FRAC        = 16;
    localparam int OUT_MAX         = 262143;
    localparam int OUT_MIN         = -262144;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOT_INC = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic signed [VAL_W-1:0] OUT_ONE = VAL_W'(1) << OUT_FRAC;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHKN, S_SRCH, S_FETCH, S_DIV_T, S_DIV_R0, S_DIV_R2,
        S_MUL_T2, S_MUL_T3, S_PREP, S_MAC_A, S_MAC_B, S_ROUND, S_FINISH
    } t_state;

endpackage
`default_nettype wire

@@ rtl/vhi_if.sv @@
// Valid/ready channel interfaces for the interpolator's input and result
// transactions. Depends on vhi_pkg for field widths.
`default_nettype none
interface vhi_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic [vhi_pkg::TIME_W-1:0]   time_point;
    logic                         voiced;
    modport source (output valid, mode, time_point, voiced, input ready);
    modport sink   (input valid, mode, time_point, voiced, output ready);
endinterface

interface vhi_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [vhi_pkg::VAL_W-1:0] voicing_value;
    logic [1:0]                       status;
    modport source (output valid, voicing_value, status, input ready);
    modport sink   (input valid, voicing_value, status, output ready);
endinterface
`default_nettype wire

@@ rtl/vhi_table_ram.sv @@
// Entry table memory: one write port, one read port, registered read data.
// Standalone; no package dependency.
`default_nettype none
module vhi_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/vhi_divider.sv @@
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Standalone; no package dependency.
`default_nettype none
module vhi_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output      logic             o_done,
    output      logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        trial  = {r_rem, r_num[NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract where it fits
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule
`default_nettype wire

@@ rtl/voicing_hermite_interpolator_unit.sv @@
// Voicing Hermite interpolator. Append, clear and no-op transactions go from acceptance
// to the finish state and from there into the result register once it is free.
// A query's time from acceptance to the result register is set by up to three serial
// divisions and the binary search, with one table read per cycle, and a stalled result
// sink adds to it. One item is in work at a time.
// Synchronous active-low reset empties the table.
`default_nettype none
module voicing_hermite_interpolator_unit #(
    parameter int TABLE_DEPTH = vhi_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = vhi_pkg::FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vhi_in_if.sink      i_in,
    vhi_out_if.source   o_out
);
    localparam int TW_  = vhi_pkg::TIME_W;
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int DW   = TW_ + 1;
    localparam int NUM_W = TW_ + FRAC_BITS;
    localparam int RW   = FRAC_BITS + vhi_pkg::RATIO_EXTRA + 1;
    localparam int HW   = FRAC_BITS + 3;
    localparam int TW   = RW + 1;
    localparam int PW   = HW + TW;
    localparam int ACCW = 2 * FRAC_BITS + 17;
    localparam int SH   = 2 * FRAC_BITS + 1 - vhi_pkg::OUT_FRAC;
    localparam int VW   = vhi_pkg::VAL_W;

    localparam logic [NUM_W-1:0] LIM_Q =
        NUM_W'(1) << (FRAC_BITS + vhi_pkg::RATIO_EXTRA);
    localparam logic [RW-1:0]        ONE_R = RW'(1) << FRAC_BITS;
    localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
    localparam logic signed [HW:0]   ONE_H = (HW + 1)'(1) << FRAC_BITS;

    // Scale a tangent term by a difference of flags, which is -1, 0 or +1.
    function automatic logic signed [TW-1:0] scale_d(input logic signed [1:0] d,
                                                     input logic signed [TW-1:0] v);
        logic signed [TW-1:0] res;
        res = '0;
        if (d == 2'sd1) begin
            res = v;
        end else if (d == -2'sd1) begin
            res = -v;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    vhi_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [TW_-1:0]  r_last, n_last;
    logic [TW_-1:0]  r_x, n_x;
    logic [AW-1:0]   r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [2:0]      r_k, n_k;
    logic [TW_-1:0]  r_tw [4];
    logic [TW_-1:0]  n_tw [4];
    logic            r_vw [4];
    logic            n_vw [4];
    logic [FRAC_BITS-1:0] r_tq, n_tq, r_t2, n_t2, r_t3, n_t3;
    logic [RW-1:0]   r_r0, n_r0, r_r2, n_r2;
    logic signed [HW-1:0]   r_h10, n_h10, r_h11, n_h11;
    logic signed [TW-1:0]   r_tan0, n_tan0, r_tan1, n_tan1;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic            r_div_run, n_div_run;
    logic signed [VW-1:0] r_res_value, n_res_value;
    logic [1:0]      r_res_status, n_res_status;
    logic            r_out_valid, n_out_valid;
    logic signed [VW-1:0] r_out_value, n_out_value;
    logic [1:0]      r_out_status, n_out_status;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;
    logic [TW_-1:0] rd_time;
    logic           rd_voiced;

    // divider port
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot, q_sat;
    logic [TW_-1:0]   div_den;

    // shared multiplier
    logic signed [HW-1:0] m_a;
    logic signed [TW-1:0] m_b;
    logic signed [PW-1:0] m_prod;

    // query helpers
    logic              acc_in;
    logic              has_prev, has_next;
    logic [CW-1:0]     cm1;
    logic              ge;
    logic [AW-1:0]     s_lo, s_hi, s_mid;
    logic [1:0]        slot;
    logic signed [1:0] d0, d1, d2;
    logic signed [HW:0] e_tq, e_t2, e_t3, h00_w, h10_w, h01_w, h11_w;
    logic signed [ACCW-1:0] sh_acc;

    vhi_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW), .DW(DW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    vhi_divider #(.NUM_W(NUM_W), .DEN_W(TW_)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign rd_time   = ram_rdata[TW_-1:0];
    assign rd_voiced = ram_rdata[TW_];
    assign m_prod    = m_a * m_b;
    assign q_sat     = (div_quot > LIM_Q) ? LIM_Q : div_quot;

    assign i_in.ready  = (r_state == vhi_pkg::S_IDLE);
    assign acc_in      = i_in.valid && i_in.ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.voicing_value = r_out_value;
    assign o_out.status        = r_out_status;

    // Window slots: 0 = entry i-1, 1 = i, 2 = i+1, 3 = i+2.
    assign has_prev = (r_lo != '0);
    assign has_next = ((CW'(r_lo) + CW'(2)) < r_count);
    assign cm1      = r_count - CW'(1);
    assign ge       = (rd_time <= r_x);
    assign s_lo     = ge ? r_mid : r_lo;
    assign s_hi     = ge ? r_hi : r_mid;
    assign s_mid    = s_lo + ((s_hi - s_lo) >> 1);
    assign slot     = 2'(r_k - 3'd1);

    // Hermite basis from the registered powers of t.
    assign d1 = $signed({1'b0, r_vw[2]}) - $signed({1'b0, r_vw[1]});
    assign d0 = has_prev ? $signed({1'b0, r_vw[1]}) - $signed({1'b0, r_vw[0]}) : d1;
    assign d2 = has_next ? $signed({1'b0, r_vw[3]}) - $signed({1'b0, r_vw[2]}) : d1;
    assign e_tq  = $signed({4'b0, r_tq});
    assign e_t2  = $signed({4'b0, r_t2});
    assign e_t3  = $signed({4'b0, r_t3});
    assign h00_w = (e_t3 <<< 1) - (e_t2 + (e_t2 <<< 1)) + ONE_H;
    assign h10_w = e_t3 - (e_t2 <<< 1) + e_tq;
    assign h01_w = (e_t2 + (e_t2 <<< 1)) - (e_t3 <<< 1);
    assign h11_w = e_t3 - e_t2;
    assign sh_acc = r_acc >>> SH;

    // ---------------------------------------------------------------------
    // Sequencer: next state, memory and divider control, datapath updates
    // ---------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_last       = r_last;
        n_x          = r_x;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_k          = r_k;
        n_tw         = r_tw;
        n_vw         = r_vw;
        n_tq         = r_tq;
        n_t2         = r_t2;
        n_t3         = r_t3;
        n_r0         = r_r0;
        n_r2         = r_r2;
        n_h10        = r_h10;
        n_h11        = r_h11;
        n_tan0       = r_tan0;
        n_tan1       = r_tan1;
        n_acc        = r_acc;
        n_div_run    = r_div_run;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {i_in.voiced, i_in.time_point};
        ram_raddr = '0;
        div_start = 1'b0;
        div_num   = {r_tw[2] - r_tw[1], {FRAC_BITS{1'b0}}};
        div_den   = r_tw[1] - r_tw[0];
        m_a       = r_h10;
        m_b       = r_tan0;

        // drop the result once the sink takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            vhi_pkg::S_IDLE: begin
                if (acc_in) begin
                    n_res_value  = '0;
                    n_res_status = vhi_pkg::ST_OK;
                    n_x          = i_in.time_point;
                    n_state      = vhi_pkg::S_FINISH;
                    case (i_in.mode)
                        vhi_pkg::MODE_APPEND: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_res_status = vhi_pkg::ST_FULL;
                            end else if (r_count != '0 && i_in.time_point <= r_last) begin
                                n_res_status = vhi_pkg::ST_NOT_INC;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_last  = i_in.time_point;
                            end
                        end
                        vhi_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                        vhi_pkg::MODE_QUERY: begin
                            if (r_count == '0) begin
                                n_res_status = vhi_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = '0;
                                n_state   = vhi_pkg::S_CHK0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            vhi_pkg::S_CHK0: begin
                // before the first entry: hold its flag
                if (r_x < rd_time) begin
                    n_res_value = rd_voiced ? vhi_pkg::OUT_ONE : '0;
                    n_state     = vhi_pkg::S_FINISH;
                end else begin
                    ram_raddr = cm1[AW-1:0];
                    n_state   = vhi_pkg::S_CHKN;
                end
            end
            vhi_pkg::S_CHKN: begin
                // at or after the last entry: hold its flag
                if (r_x >= rd_time) begin
                    n_res_value = rd_voiced ? vhi_pkg::OUT_ONE : '0;
                    n_state     = vhi_pkg::S_FINISH;
                end else if (cm1[AW-1:0] > AW'(1)) begin
                    n_lo      = '0;
                    n_hi      = cm1[AW-1:0];
                    n_mid     = cm1[AW-1:0] >> 1;
                    ram_raddr = cm1[AW-1:0] >> 1;
                    n_state   = vhi_pkg::S_SRCH;
                end else begin
                    n_lo    = '0;
                    n_k     = '0;
                    n_state = vhi_pkg::S_FETCH;
                end
            end
            vhi_pkg::S_SRCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if ((s_hi - s_lo) > AW'(1)) begin
                    n_mid     = s_mid;
                    ram_raddr = s_mid;
                end else begin
                    n_k     = '0;
                    n_state = vhi_pkg::S_FETCH;
                end
            end
            vhi_pkg::S_FETCH: begin
                // one read a cycle, captured into the window in the cycle after its read
                if (r_k != '0) begin
                    n_tw[slot] = rd_time;
                    n_vw[slot] = rd_voiced;
                end
                if (r_k == 3'd4) begin
                    n_state = vhi_pkg::S_DIV_T;
                end else begin
                    ram_raddr = r_lo - AW'(1) + AW'(r_k);
                    n_k       = r_k + 3'd1;
                end
            end
            vhi_pkg::S_DIV_T: begin
                div_num = {r_x - r_tw[1], {FRAC_BITS{1'b0}}};
                div_den = r_tw[2] - r_tw[1];
                if (!r_div_run) begin
                    div_start = 1'b1;
                    n_div_run = 1'b1;
                end else if (div_done) begin
                    n_div_run = 1'b0;
                    n_tq      = div_quot[FRAC_BITS-1:0];
                    n_state   = vhi_pkg::S_DIV_R0;
                end
            end
            vhi_pkg::S_DIV_R0: begin
                div_den = r_tw[1] - r_tw[0];
                if (!has_prev) begin
                    n_r0    = ONE_R;
                    n_state = vhi_pkg::S_DIV_R2;
                end else if (!r_div_run) begin
                    div_start = 1'b1;
                    n_div_run = 1'b1;
                end else if (div_done) begin
                    n_div_run = 1'b0;
                    n_r0      = q_sat[RW-1:0];
                    n_state   = vhi_pkg::S_DIV_R2;
                end
            end
            vhi_pkg::S_DIV_R2: begin
                div_den = r_tw[3] - r_tw[2];
                if (!has_next) begin
                    n_r2    = ONE_R;
                    n_state = vhi_pkg::S_MUL_T2;
                end else if (!r_div_run) begin
                    div_start = 1'b1;
                    n_div_run = 1'b1;
                end else if (div_done) begin
                    n_div_run = 1'b0;
                    n_r2      = q_sat[RW-1:0];
                    n_state   = vhi_pkg::S_MUL_T2;
                end
            end
            vhi_pkg::S_MUL_T2: begin
                m_a     = $signed({3'b0, r_tq});
                m_b     = $signed({{(TW - FRAC_BITS){1'b0}}, r_tq});
                n_t2    = m_prod[2*FRAC_BITS-1:FRAC_BITS];
                n_state = vhi_pkg::S_MUL_T3;
            end
            vhi_pkg::S_MUL_T3: begin
                m_a     = $signed({3'b0, r_t2});
                m_b     = $signed({{(TW - FRAC_BITS){1'b0}}, r_tq});
                n_t3    = m_prod[2*FRAC_BITS-1:FRAC_BITS];
                n_state = vhi_pkg::S_PREP;
            end
            vhi_pkg::S_PREP: begin
                // tangents are doubled; the flag terms carry the matching 2
                n_h10  = h10_w[HW-1:0];
                n_h11  = h11_w[HW-1:0];
                n_tan0 = scale_d(d1, ONE_T) + scale_d(d0, $signed({1'b0, r_r0}));
                n_tan1 = scale_d(d1, ONE_T) + scale_d(d2, $signed({1'b0, r_r2}));
                n_acc  = (r_vw[1] ? (ACCW'(h00_w) <<< (FRAC_BITS + 1)) : '0)
                       + (r_vw[2] ? (ACCW'(h01_w) <<< (FRAC_BITS + 1)) : '0);
                n_state = vhi_pkg::S_MAC_A;
            end
            vhi_pkg::S_MAC_A: begin
                n_acc   = r_acc + ACCW'(m_prod);
                n_state = vhi_pkg::S_MAC_B;
            end
            vhi_pkg::S_MAC_B: begin
                m_a     = r_h11;
                m_b     = r_tan1;
                n_acc   = r_acc + ACCW'(m_prod);
                n_state = vhi_pkg::S_ROUND;
            end
            vhi_pkg::S_ROUND: begin
                // floor to Q3.16, then saturate
                if (sh_acc > ACCW'(vhi_pkg::OUT_MAX)) begin
                    n_res_value = VW'(vhi_pkg::OUT_MAX);
                end else if (sh_acc < ACCW'(vhi_pkg::OUT_MIN)) begin
                    n_res_value = VW'(vhi_pkg::OUT_MIN);
                end else begin
                    n_res_value = sh_acc[VW-1:0];
                end
                n_state = vhi_pkg::S_FINISH;
            end
            vhi_pkg::S_FINISH: begin
                // hold until the result register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                    n_state      = vhi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vhi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vhi_pkg::S_IDLE;
            r_count     <= '0;
            r_div_run   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_div_run   <= n_div_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last       <= n_last;
        r_x          <= n_x;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_k          <= n_k;
        r_tw         <= n_tw;
        r_vw         <= n_vw;
        r_tq         <= n_tq;
        r_t2         <= n_t2;
        r_t3         <= n_t3;
        r_r0         <= n_r0;
        r_r2         <= n_r2;
        r_h10        <= n_h10;
        r_h11        <= n_h11;
        r_tan0       <= n_tan0;
        r_tan1       <= n_tan1;
        r_acc        <= n_acc;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> !i_in.ready)
        else $error("input ready straight after a transaction");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == vhi_pkg::ST_EMPTY) |-> (o_out.voicing_value == '0))
        else $error("empty-table result carries a value");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_div_run && (r_state == vhi_pkg::S_DIV_T ||
                      r_state == vhi_pkg::S_DIV_R0 || r_state == vhi_pkg::S_DIV_R2)))
        else $error("divider finished outside a division step");

endmodule
`default_nettype wire
